[rtl/core/adsr_envelope_generator_assert.svh]
// Assertion macros shared by the envelope generator checkers.
// Each expands to one labeled concurrent assertion clocked on clk,
// disabled while rst_n is low.
`ifndef ADSR_ENVELOPE_GENERATOR_ASSERT_SVH
`define ADSR_ENVELOPE_GENERATOR_ASSERT_SVH

// Same-cycle implication
`define ADSR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ADSR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/adsr_pkg.sv]
package adsr_pkg;

    // Output field widths
    localparam int LEVEL_OUT_W = 12;
    localparam int PHASE_W     = 3;
    localparam int SUSTAIN_W   = 12;
    localparam int COEF_W      = 16;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;

    // Sustain default is half scale, coefficient default about 0.999
    localparam logic [SUSTAIN_W-1:0] SUSTAIN_RESET = 12'd2048;
    localparam logic [COEF_W-1:0]    COEF_RESET    = 16'd65470;

    typedef enum logic [PHASE_W-1:0] {
        PH_OFF     = 3'd0,
        PH_ATTACK  = 3'd1,
        PH_DECAY   = 3'd2,
        PH_SUSTAIN = 3'd3,
        PH_RELEASE = 3'd4
    } phase_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SUSTAIN    = 1'b0,
        REG_DECAY_COEF = 1'b1
    } cfg_reg_t;

    // Phase and activity travel together between the step logic and the top
    typedef struct packed {
        phase_t phase;
        logic   active;
    } adsr_ctrl_t;

    // Integer bits cover the attack target (1.2 x full scale) and the sustain field
    function automatic int level_width(input int pwm_length, input int frac_bits);
        int target_int;
        int int_w;
        target_int = (pwm_length * 6) / 5;
        int_w = $clog2(target_int + 1);
        if (int_w < LEVEL_OUT_W)
            int_w = LEVEL_OUT_W;
        return int_w + frac_bits;
    endfunction

endpackage

[rtl/core/adsr_step_logic.sv]
module adsr_step_logic #(
    parameter int PWM_LENGTH = 4096,
    parameter int FRAC_BITS  = 16,
    parameter int LEVEL_W    = 29
) (
    input  logic                              gate_on,
    input  logic [LEVEL_W-1:0]                level,
    input  adsr_pkg::adsr_ctrl_t              ctrl,
    input  logic [adsr_pkg::SUSTAIN_W-1:0]    sustain_level,
    input  logic [adsr_pkg::COEF_W-1:0]       decay_coefficient,
    output logic [LEVEL_W-1:0]                level_next,
    output adsr_pkg::adsr_ctrl_t              ctrl_next
);
    import adsr_pkg::*;

    localparam int TARGET_INT = (PWM_LENGTH * 6) / 5;
    localparam logic [LEVEL_W-1:0] TARGET   = LEVEL_W'(TARGET_INT) << FRAC_BITS;
    localparam logic [LEVEL_W-1:0] TOP      = LEVEL_W'(PWM_LENGTH - 1) << FRAC_BITS;
    localparam logic [LEVEL_W-1:0] ONE      = LEVEL_W'(1) << FRAC_BITS;
    localparam logic [LEVEL_W:0]   ONE_HALF = (LEVEL_W + 1)'(3) << (FRAC_BITS - 1);

    logic [LEVEL_W-1:0]        sus;
    logic [LEVEL_W-1:0]        mul_operand;
    logic [LEVEL_W+COEF_W-1:0] product;
    logic [LEVEL_W-1:0]        scaled;
    logic [LEVEL_W-1:0]        attack_level;
    logic [LEVEL_W-1:0]        decay_level;

    assign sus = LEVEL_W'(sustain_level) << FRAC_BITS;

    // One shared multiplier: distance to target, distance to sustain, or level
    always_comb
    begin
        mul_operand = level;
        if (gate_on)
        begin
            case (ctrl.phase)
                PH_ATTACK: mul_operand = TARGET - level;
                PH_DECAY:  mul_operand = level - sus;
                default:   mul_operand = level;
            endcase
        end
    end

    assign product = (LEVEL_W + COEF_W)'(mul_operand) * (LEVEL_W + COEF_W)'(decay_coefficient);
    assign scaled  = product[LEVEL_W+COEF_W-1:COEF_W];

    assign attack_level = (level >= TARGET) ? TARGET : TARGET - scaled;
    assign decay_level  = (level > sus) ? sus + scaled : level;

    // Phase transitions and level update for one tick
    always_comb
    begin
        level_next = level;
        ctrl_next  = ctrl;
        if (gate_on)
        begin
            ctrl_next.active = 1'b1;
            case (ctrl.phase)
                PH_ATTACK:
                begin
                    level_next = attack_level;
                    if (attack_level >= TOP)
                    begin
                        level_next      = TOP;
                        ctrl_next.phase = PH_DECAY;
                    end
                end
                PH_DECAY:
                begin
                    level_next = decay_level;
                    if ({1'b0, decay_level} <= ({1'b0, sus} + ONE_HALF))
                    begin
                        level_next      = sus;
                        ctrl_next.phase = PH_SUSTAIN;
                    end
                end
                PH_SUSTAIN: level_next = sus;
                default:    ctrl_next.phase = PH_ATTACK;
            endcase
        end
        else if (level != '0)
        begin
            ctrl_next.phase = PH_RELEASE;
            level_next      = (level > ONE) ? scaled : '0;
        end
        else
        begin
            ctrl_next.phase  = PH_OFF;
            ctrl_next.active = 1'b0;
        end
    end

endmodule

[rtl/core/adsr_envelope_generator.sv]
// Each accepted tick's result is registered in the output register and shown on m_axis.
// Throughput: one tick per cycle; the level/phase update is a single pass through
// one multiplier between the state registers, and the output register lets a new
// tick in while the previous result waits, as long as m_axis_tready is high.
// Reset (rst_n low, asynchronous): level 0, phase off, inactive, registers at
// sustain 2048 and coefficient 65470, no result pending.
module adsr_envelope_generator #(
    parameter int PWM_LENGTH = 4096,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // tick input
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [adsr_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // [0] gate_on, rest zero
    // envelope output
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [adsr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,   // [11:0] level, [14:12] phase,
                                                                // [15] active
    // register writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [adsr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [adsr_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import adsr_pkg::*;

    localparam int LEVEL_W = level_width(PWM_LENGTH, FRAC_BITS);

    logic [LEVEL_W-1:0]         level_reg;
    logic [LEVEL_W-1:0]         level_next;
    adsr_ctrl_t                 ctrl_reg;
    adsr_ctrl_t                 ctrl_next;
    logic [SUSTAIN_W-1:0]       sustain_reg;
    logic [COEF_W-1:0]          coef_reg;
    logic                       out_valid_reg;
    logic [OUT_TDATA_W-1:0]     out_data_reg;
    logic                       in_fire;

    // Output register frees up when empty or being drained
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    adsr_step_logic #(
        .PWM_LENGTH (PWM_LENGTH),
        .FRAC_BITS  (FRAC_BITS),
        .LEVEL_W    (LEVEL_W)
    ) u_step (
        .gate_on           (s_axis_tdata[0]),
        .level             (level_reg),
        .ctrl              (ctrl_reg),
        .sustain_level     (sustain_reg),
        .decay_coefficient (coef_reg),
        .level_next        (level_next),
        .ctrl_next         (ctrl_next)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sustain_reg <= SUSTAIN_RESET;
            coef_reg    <= COEF_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_SUSTAIN)
                sustain_reg <= cfg_data[SUSTAIN_W-1:0];
            else if (cfg_index == REG_DECAY_COEF)
                coef_reg <= cfg_data[COEF_W-1:0];
        end
    end

    // Envelope state, advanced once per accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
            ctrl_reg  <= '{phase: PH_OFF, active: 1'b0};
        end
        else if (in_fire)
        begin
            level_reg <= level_next;
            ctrl_reg  <= ctrl_next;
        end
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
            out_data_reg <= {ctrl_next.active, ctrl_next.phase,
                             level_next[FRAC_BITS +: LEVEL_OUT_W]};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

[rtl/core/adsr_checker.sv]
`include "adsr_envelope_generator_assert.svh"

module adsr_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic [adsr_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [adsr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input logic                                cfg_valid,
    input logic                                cfg_ready,
    input logic [adsr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input logic [adsr_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import adsr_pkg::*;

    logic   in_fire;
    logic   out_stall;
    phase_t out_phase;
    logic   out_active;
    logic   unused_cfg;

    assign in_fire    = s_axis_tvalid && s_axis_tready;
    assign out_stall  = m_axis_tvalid && !m_axis_tready;
    assign out_phase  = phase_t'(m_axis_tdata[14:12]);
    assign out_active = m_axis_tdata[15];
    assign unused_cfg = cfg_valid & cfg_ready & (^cfg_index) & (^cfg_data);

    // Stalled result holds
    `ADSR_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(m_axis_tdata),
        "result changed while stalled")

    // Every accepted tick yields a result in the next cycle
    `ADSR_ASSERT_NEXT(a_tick_result, in_fire, m_axis_tvalid,
        "accepted tick produced no result")

    // Gate on always marks the envelope active
    `ADSR_ASSERT_NEXT(a_gate_active, in_fire && s_axis_tdata[0], out_active,
        "gate on did not set active")

    // Off phase means zero level and inactive; active exactly when not off
    `ADSR_ASSERT_SAME(a_off_zero, m_axis_tvalid && (out_phase == PH_OFF),
        (m_axis_tdata[11:0] == '0) && !out_active, "off phase with level or active set")

    `ADSR_ASSERT_SAME(a_active_phase, m_axis_tvalid,
        out_active == (out_phase != PH_OFF), "active flag disagrees with phase")

endmodule

bind adsr_envelope_generator adsr_checker u_adsr_checker (.*);

[sim/adsr_envelope_generator_tb.sv]
module adsr_envelope_generator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import adsr_pkg::*;

    // Fixed-point layout at the block's default parameters
    localparam int FRAC_BITS   = 16;
    localparam int FULL_SCALE  = 4096;
    localparam logic [63:0] ATTACK_TARGET = 64'((FULL_SCALE * 6) / 5) << FRAC_BITS;
    localparam logic [63:0] LEVEL_TOP     = 64'(FULL_SCALE - 1) << FRAC_BITS;
    localparam logic [63:0] LVL_ONE       = 64'd1 << FRAC_BITS;
    localparam logic [63:0] LVL_ONE_HALF  = 64'd3 << (FRAC_BITS - 1);

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RAND_PHASES   = 8;
    localparam int PHASE_TICKS   = 180;
    localparam int HOLD_AFTER    = 600;
    localparam int HOLD_CYCLES   = 300;

    typedef struct packed {
        logic [LEVEL_OUT_W-1:0] level;
        phase_t                 phase;
        logic                   active;
    } env_out_t;

    typedef enum logic {
        ROW_TICK = 1'b0,
        ROW_CFG  = 1'b1
    } row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        cfg_reg_t               reg_sel;
        logic [CFG_DATA_W-1:0]  data;
        logic                   gate;
        logic                   typed;
        env_out_t               out;
    } env_row_t;

    logic                       clk;
    logic                       rst_n;
    logic                       s_axis_tvalid;
    logic                       s_axis_tready;
    logic [IN_TDATA_W-1:0]      s_axis_tdata;   // [0] gate_on, rest zero
    logic                       m_axis_tvalid;
    logic                       m_axis_tready;
    logic [OUT_TDATA_W-1:0]     m_axis_tdata;   // [11:0] level, [14:12] phase, [15] active
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_INDEX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;

    // Envelope state as the block should hold it
    logic [63:0]                lvl_fx;
    phase_t                     cur_phase;
    logic                       is_active;
    logic [SUSTAIN_W-1:0]       sus_reg;
    logic [COEF_W-1:0]          coef_reg;

    env_out_t                   envelope_out_due[$];
    int                         env_errors;
    int                         env_results_seen;
    int                         cycle_count;
    int                         tx_burst;
    bit                         rx_held;

    // Directed walk: while the coefficient is 0 every step lands on its target at once
    env_row_t dir_rows [32] = '{
        '{ROW_TICK, REG_SUSTAIN,    16'd0,     1'b0, 1'b1, '{12'd0,    PH_OFF,     1'b0}},
        '{ROW_TICK, REG_SUSTAIN,    16'd0,     1'b1, 1'b1, '{12'd0,    PH_ATTACK,  1'b1}},
        '{ROW_TICK, REG_SUSTAIN,    16'd0,     1'b1, 1'b0, '{12'd0,    PH_OFF,     1'b0}},
        '{ROW_CFG,  REG_DECAY_COEF, 16'd0,     1'b0, 1'b0, '{12'd0,    PH_OFF,     1'b0}},
        '{ROW_TICK, REG_SUSTAIN,    16'd0,     1'b1, 1'b1, '{12'd4095, PH_DECAY,   1'b1}},
        '{ROW_TICK, REG_SUSTAIN,    16'd0,     1'b1, 1'b1, '{12'd2048, PH_SUSTAIN, 1'b1}},
        '{ROW_CFG,  REG_SUSTAIN,    16'd4095,  1'b0, 1'b0, '{12'd0,    PH_OFF,     1'b0}},
        '{ROW_TICK, REG_SUSTAIN,    16'd0,     1'b1, 1'b1, '{12'd4095, PH_SUSTAIN, 1'b1}},
        '{ROW_CFG,  REG_SUSTAIN,    16'd0,     1'b0, 1'b0, '{12'd0,    PH_OFF,     1'b0}},
        '{ROW_TICK, REG_SUSTAIN,    16'd0,     1'b1, 1'b1, '{12'd0,    PH_SUSTAIN, 1'b1}},
        '{ROW_TICK, REG_SUSTAIN,    16'd0,     1'b0, 1'b1, '{12'd0,    PH_OFF,     1'b0}},
        '{ROW_TICK, REG_SUSTAIN,    16'd0,     1'b1, 1'b1, '{12'd0,    PH_ATTACK,  1'b1}},
        '{ROW_TICK, REG_SUSTAIN,    16'd0,     1'b1, 1'b1, '{12'd4095, PH_DECAY,   1'b1}},
        '{ROW_TICK, REG_SUSTAIN,    16'd0,     1'b0, 1'b1, '{12'd0,    PH_RELEASE, 1'b1}},
        '{ROW_TICK, REG_SUSTAIN,    16'd0,     1'b1, 1'b1, '{12'd0,    PH_ATTACK,  1'b1}},
        '{ROW_TICK, REG_SUSTAIN,    16'd0,     1'b1, 1'b1, '{12'd4095, PH_DECAY,   1'b1}},
        '{ROW_CFG,  REG_SUSTAIN,    16'd1,     1'b0, 1'b0, '{12'd0,    PH_OFF,     1'b0}},
        '{ROW_TICK, REG_SUSTAIN,    16'd0,     1'b1, 1'b1, '{12'd1,    PH_SUSTAIN, 1'b1}},
        '{ROW_TICK, REG_SUSTAIN,    16'd0,     1'b0, 1'b1, '{12'd0,    PH_RELEASE, 1'b1}},
        '{ROW_TICK, REG_SUSTAIN,    16'd0,     1'b0, 1'b1, '{12'd0,    PH_OFF,     1'b0}},
        '{ROW_TICK, REG_SUSTAIN,    16'd0,     1'b1, 1'b1, '{12'd0,    PH_ATTACK,  1'b1}},
        '{ROW_TICK, REG_SUSTAIN,    16'd0,     1'b1, 1'b1, '{12'd4095, PH_DECAY,   1'b1}},
        '{ROW_CFG,  REG_SUSTAIN,    16'd2,     1'b0, 1'b0, '{12'd0,    PH_OFF,     1'b0}},
        '{ROW_TICK, REG_SUSTAIN,    16'd0,     1'b1, 1'b1, '{12'd2,    PH_SUSTAIN, 1'b1}},
        '{ROW_CFG,  REG_DECAY_COEF, 16'd65535, 1'b0, 1'b0, '{12'd0,    PH_OFF,     1'b0}},
        '{ROW_TICK, REG_SUSTAIN,    16'd0,     1'b0, 1'b0, '{12'd0,    PH_OFF,     1'b0}},
        '{ROW_TICK, REG_SUSTAIN,    16'd0,     1'b0, 1'b0, '{12'd0,    PH_OFF,     1'b0}},
        '{ROW_TICK, REG_SUSTAIN,    16'd0,     1'b1, 1'b0, '{12'd0,    PH_OFF,     1'b0}},
        '{ROW_TICK, REG_SUSTAIN,    16'd0,     1'b1, 1'b0, '{12'd0,    PH_OFF,     1'b0}},
        '{ROW_CFG,  REG_DECAY_COEF, 16'd32768, 1'b0, 1'b0, '{12'd0,    PH_OFF,     1'b0}},
        '{ROW_TICK, REG_SUSTAIN,    16'd0,     1'b1, 1'b0, '{12'd0,    PH_OFF,     1'b0}},
        '{ROW_TICK, REG_SUSTAIN,    16'd0,     1'b0, 1'b0, '{12'd0,    PH_OFF,     1'b0}}
    };

    adsr_envelope_generator u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Multiply by the Q0.16 coefficient, truncating
    function automatic logic [63:0] coef_scale(input logic [63:0] v);
        return (v * 64'(coef_reg)) >> COEF_W;
    endfunction

    // One envelope tick: update the level/phase copy and return the output
    function automatic env_out_t envelope_advance(input logic gate);
        logic [63:0] sus_fx;
        env_out_t    r;
        sus_fx = 64'(sus_reg) << FRAC_BITS;
        if (gate)
        begin
            is_active = 1'b1;
            case (cur_phase)
                PH_ATTACK:
                begin
                    if (lvl_fx >= ATTACK_TARGET)
                        lvl_fx = ATTACK_TARGET;
                    else
                        lvl_fx = ATTACK_TARGET - coef_scale(ATTACK_TARGET - lvl_fx);
                    if (lvl_fx >= LEVEL_TOP)
                    begin
                        lvl_fx    = LEVEL_TOP;
                        cur_phase = PH_DECAY;
                    end
                end
                PH_DECAY:
                begin
                    if (lvl_fx > sus_fx)
                        lvl_fx = sus_fx + coef_scale(lvl_fx - sus_fx);
                    // within 1.5 of sustain: snap
                    if (lvl_fx <= sus_fx + LVL_ONE_HALF)
                    begin
                        lvl_fx    = sus_fx;
                        cur_phase = PH_SUSTAIN;
                    end
                end
                PH_SUSTAIN:
                    lvl_fx = sus_fx;
                default:
                    cur_phase = PH_ATTACK;
            endcase
        end
        else if (lvl_fx > 0)
        begin
            cur_phase = PH_RELEASE;
            lvl_fx    = (lvl_fx > LVL_ONE) ? coef_scale(lvl_fx) : 64'd0;
        end
        else
        begin
            cur_phase = PH_OFF;
            is_active = 1'b0;
        end
        r.level  = lvl_fx[FRAC_BITS +: LEVEL_OUT_W];
        r.phase  = cur_phase;
        r.active = is_active;
        return r;
    endfunction

    // Drop tvalid and let every outstanding envelope output come back
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (envelope_out_due.size() != 0)
            @(posedge clk);
    endtask

    // Register write transaction; cfg_valid is lowered by the next tick
    task automatic reg_write(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] data);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (sel == REG_SUSTAIN)
            sus_reg = data[SUSTAIN_W-1:0];
        else
            coef_reg = data;
    endtask

    // Tick transaction with burst/gap pacing; typed rows override the prediction
    task automatic send_tick(input logic gate, input logic typed, input env_out_t typed_out);
        env_out_t want;
        int       gap;
        cfg_valid <= 1'b0;
        if (tx_burst == 0)
        begin
            tx_burst = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        tx_burst--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W-1){1'b0}}, gate};
        do
            @(posedge clk);
        while (!s_axis_tready);
        want = envelope_advance(gate);
        if (typed)
            want = typed_out;
        envelope_out_due.push_back(want);
    endtask

    // Output side: compare each transaction with the oldest prediction
    always @(posedge clk)
    begin : out_check
        env_out_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            env_results_seen++;
            if (envelope_out_due.size() == 0)
            begin
                $display("%0t unexpected output tdata=%h", $time, m_axis_tdata);
                env_errors++;
            end
            else
            begin
                want = envelope_out_due.pop_front();
                if (m_axis_tdata[11:0] != want.level)
                begin
                    $display("%0t level: expected %0d, actual %0d",
                             $time, want.level, m_axis_tdata[11:0]);
                    env_errors++;
                end
                if (m_axis_tdata[14:12] != want.phase)
                begin
                    $display("%0t phase: expected %0d, actual %0d",
                             $time, want.phase, m_axis_tdata[14:12]);
                    env_errors++;
                end
                if (m_axis_tdata[15] != want.active)
                begin
                    $display("%0t active: expected %0d, actual %0d",
                             $time, want.active, m_axis_tdata[15]);
                    env_errors++;
                end
            end
        end
    end

    // Receiver: runs of full speed, stalls, alternation and random, plus one long hold-off
    initial
    begin : rx_pattern
        int left;
        int mode;
        left = 0;
        mode = 0;
        rx_held = 1'b0;
        m_axis_tready <= 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (!rx_held && env_results_seen >= HOLD_AFTER)
            begin
                rx_held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                left = 0;
            end
            else
            begin
                if (left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    left = (mode == 0) ? $urandom_range(20, 100) : $urandom_range(1, 8);
                end
                left--;
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'b0;
                    2: m_axis_tready <= left[0];
                    default: m_axis_tready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("adsr_envelope_generator: mismatch");
            $finish;
        end
    end

    initial
    begin : stim_main
        int       rp;
        int       n_sent;
        int       n_on;
        int       n_off;
        int       k;
        int       sus_val;
        int       coef_val;
        env_out_t none;
        none          = '0;
        env_errors    = 0;
        env_results_seen = 0;
        cycle_count   = 0;
        tx_burst      = 0;
        sus_reg       = SUSTAIN_RESET;
        coef_reg      = COEF_RESET;
        lvl_fx        = '0;
        cur_phase     = PH_OFF;
        is_active     = 1'b0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cfg_valid     <= 1'b0;
        cfg_index     <= REG_SUSTAIN;
        cfg_data      <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
                reg_write(dir_rows[i].reg_sel, dir_rows[i].data);
            else
                send_tick(dir_rows[i].gate, dir_rows[i].typed, dir_rows[i].out);
        end

        // Random notes under several register settings, extremes first
        for (rp = 0; rp < RAND_PHASES; rp++)
        begin
            sus_val  = $urandom_range(0, 4095);
            coef_val = $urandom_range(40000, 64800);
            case (rp)
                0: coef_val = 0;
                1: begin sus_val = 4095; coef_val = $urandom_range(58000, 64000); end
                2: begin sus_val = 0; coef_val = $urandom_range(58000, 64000); end
                3: coef_val = 65535;
                default: ;
            endcase
            // upper data bits are don't-care for the sustain register
            reg_write(REG_SUSTAIN, {4'($urandom_range(0, 15)), 12'(sus_val)});
            reg_write(REG_DECAY_COEF, 16'(coef_val));
            n_sent = 0;
            while (n_sent < PHASE_TICKS)
            begin
                if ($urandom_range(0, 99) < 85)
                begin
                    // well-formed note: press, then release
                    n_on  = $urandom_range(1, 100);
                    n_off = $urandom_range(1, 80);
                    repeat (n_on) send_tick(1'b1, 1'b0, none);
                    repeat (n_off) send_tick(1'b0, 1'b0, none);
                    n_sent += n_on + n_off;
                end
                else
                begin
                    k = $urandom_range(1, 8);
                    repeat (k) send_tick(1'($urandom_range(0, 1)), 1'b0, none);
                    n_sent += k;
                end
            end
        end

        wait_idle();
        repeat (4) @(posedge clk);
        if (env_errors == 0)
            $display("adsr_envelope_generator: match");
        else
            $display("adsr_envelope_generator: mismatch");
        $finish;
    end

endmodule

[adsr_envelope_generator.f]
+incdir+rtl/core
rtl/core/adsr_pkg.sv
rtl/core/adsr_step_logic.sv
rtl/core/adsr_envelope_generator.sv
rtl/core/adsr_checker.sv
sim/adsr_envelope_generator_tb.sv
